// ----- rtl/lfu_pkg.sv -----
// shared types and constants for the lfu slot replacement block
`default_nettype none

package lfu_pkg;

    // field widths fixed by the item format
    localparam int ID_W   = 7;
    localparam int CFG_W  = 6;
    localparam int CNT_W  = 16;
    localparam int KIND_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
    localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = 6'd20;

    // most ids reported by one list command
    localparam int LIST_MAX = 32;
    localparam int LIST_W   = 6;

    // command codes
    localparam logic [1:0] CMD_VOTE  = 2'd0;
    localparam logic [1:0] CMD_LIST  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_HIT      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EVICTED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LISTED   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEARED  = 3'd5;

    typedef struct packed {
        logic [1:0]      command;
        logic [ID_W-1:0] candidate_id;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   result_id;
        logic              last;
    } out_item_t;

    // one slot of the table
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] stamp;
    } slot_entry_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clr_start;
        logic clr_step;
        logic scan_start;
        logic scan_step;
        logic hit_write;
        logic evict_map;
        logic insert_write;
        logic list_start;
        logic list_rd;
        logic list_emit;
        logic res_empty;
        logic res_cleared;
    } lfu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] command;
        logic       id_ok;
        logic       count_zero;
        logic       clr_done;
        logic       scan_last;
        logic       hit;
        logic       need_evict;
        logic       map_bit;
        logic       res_last;
    } lfu_stat_t;

endpackage

`default_nettype wire

// ----- rtl/lfu_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lfu_datapath.sv -----
// slot table, resident bitmap, scan trackers and result staging
`default_nettype none

module lfu_datapath #(
    parameter int MAX_SLOTS = 32,
    parameter int ID_COUNT  = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire lfu_pkg::in_item_t        s_item,
    input  wire logic                     cfg_wr_en,
    input  wire logic [lfu_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire lfu_pkg::lfu_cmd_t        cmd,
    output lfu_pkg::lfu_stat_t            stat,
    output lfu_pkg::out_item_t            res
);

    import lfu_pkg::*;

    localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int MAP_AW  = $clog2(ID_COUNT);
    localparam int CNT_SW  = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W   = (CNT_SW > CFG_W) ? CNT_SW : CFG_W;
    localparam int ENTRY_W = $bits(slot_entry_t);

    // control state
    logic [CFG_W-1:0]     slot_count_reg;
    logic [CNT_W-1:0]     vote_index_reg, vote_index_next;
    logic [CNT_SW-1:0]    count_reg;
    logic [MAX_SLOTS-1:0] slot_valid_reg;
    logic [SLOT_AW:0]     ptr_reg;
    logic [MAP_AW:0]      mptr_reg;
    logic [LIST_W-1:0]    emitted_reg;
    logic                 ev_vld_reg;
    logic                 match_found_reg, victim_found_reg, free_found_reg;

    // payload
    in_item_t             item_reg;
    logic [SLOT_AW-1:0]   ev_idx_reg;
    logic [SLOT_AW-1:0]   match_idx_reg, victim_idx_reg, free_idx_reg;
    slot_entry_t          match_entry_reg, victim_entry_reg;
    logic [MAP_AW-1:0]    laddr_reg;
    out_item_t            res_reg;

    // memories
    logic                 slot_we;
    logic [SLOT_AW-1:0]   slot_waddr;
    slot_entry_t          slot_wdata;
    logic [ENTRY_W-1:0]   slot_rdata;
    slot_entry_t          ev_entry;

    logic                 map_we;
    logic [MAP_AW-1:0]    map_waddr;
    logic                 map_wdata;
    logic [0:0]           map_rdata;

    logic                 ev_valid, better_victim;
    logic [CMP_W-1:0]     sc_ext, cap, cnt_ext, list_total;
    logic                 need_evict;
    logic [SLOT_AW-1:0]   target_idx;
    logic [CNT_W-1:0]     hits_inc;

    lfu_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (slot_wdata),
        .rd_en   (cmd.scan_step),
        .rd_addr (ptr_reg[SLOT_AW-1:0]),
        .rd_data (slot_rdata)
    );

    lfu_ram #(.WIDTH(1), .DEPTH(ID_COUNT)) u_map_ram (
        .aclk    (aclk),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_en   (cmd.list_rd),
        .rd_addr (mptr_reg[MAP_AW-1:0]),
        .rd_data (map_rdata)
    );

    // capacity clamped to 1..MAX_SLOTS
    always_comb begin
        sc_ext = CMP_W'(slot_count_reg);
        if (sc_ext == '0) begin
            cap = CMP_W'(1);
        end else if (sc_ext > CMP_W'(MAX_SLOTS)) begin
            cap = CMP_W'(MAX_SLOTS);
        end else begin
            cap = sc_ext;
        end
        cnt_ext    = CMP_W'(count_reg);
        need_evict = (cnt_ext >= cap);
        list_total = (cnt_ext > CMP_W'(LIST_MAX)) ? CMP_W'(LIST_MAX) : cnt_ext;
    end

    // scan evaluation of the slot read last cycle
    always_comb begin
        ev_entry      = slot_entry_t'(slot_rdata);
        ev_valid      = ev_vld_reg && slot_valid_reg[ev_idx_reg];
        better_victim = !victim_found_reg
                        || (ev_entry.hits < victim_entry_reg.hits)
                        || ((ev_entry.hits == victim_entry_reg.hits)
                            && (ev_entry.stamp < victim_entry_reg.stamp));
    end

    always_comb begin
        target_idx      = need_evict ? victim_idx_reg : free_idx_reg;
        hits_inc        = (match_entry_reg.hits != CNT_MAX) ?
                          match_entry_reg.hits + CNT_W'(1) : match_entry_reg.hits;
        vote_index_next = (vote_index_reg != CNT_MAX) ?
                          vote_index_reg + CNT_W'(1) : vote_index_reg;
    end

    // slot write port
    always_comb begin
        slot_we    = cmd.hit_write || cmd.insert_write;
        slot_waddr = cmd.hit_write ? match_idx_reg : target_idx;
        if (cmd.hit_write) begin
            slot_wdata = '{id: match_entry_reg.id, hits: hits_inc,
                           stamp: match_entry_reg.stamp};
        end else begin
            slot_wdata = '{id: item_reg.candidate_id, hits: CNT_W'(1),
                           stamp: vote_index_reg};
        end
    end

    // bitmap write port
    always_comb begin
        map_we    = cmd.clr_step || cmd.evict_map || cmd.insert_write;
        map_waddr = mptr_reg[MAP_AW-1:0];
        map_wdata = 1'b0;
        if (cmd.evict_map) begin
            map_waddr = MAP_AW'(victim_entry_reg.id);
        end else if (cmd.insert_write) begin
            map_waddr = MAP_AW'(item_reg.candidate_id);
            map_wdata = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg   <= SLOT_COUNT_RESET;
            vote_index_reg   <= '0;
            count_reg        <= '0;
            slot_valid_reg   <= '0;
            ptr_reg          <= '0;
            mptr_reg         <= '0;
            emitted_reg      <= '0;
            ev_vld_reg       <= 1'b0;
            match_found_reg  <= 1'b0;
            victim_found_reg <= 1'b0;
            free_found_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                slot_count_reg <= cfg_wr_data;
            end
            ev_vld_reg <= cmd.scan_step;

            if (cmd.clr_start) begin
                vote_index_reg <= '0;
                count_reg      <= '0;
                slot_valid_reg <= '0;
                mptr_reg       <= '0;
            end
            if (cmd.clr_step || cmd.list_rd) begin
                mptr_reg <= mptr_reg + (MAP_AW+1)'(1);
            end
            if (cmd.list_start) begin
                mptr_reg    <= '0;
                emitted_reg <= '0;
            end
            if (cmd.list_emit) begin
                emitted_reg <= emitted_reg + LIST_W'(1);
            end

            if (cmd.scan_start) begin
                ptr_reg          <= '0;
                match_found_reg  <= 1'b0;
                victim_found_reg <= 1'b0;
                free_found_reg   <= 1'b0;
            end
            if (cmd.scan_step) begin
                ptr_reg <= ptr_reg + (SLOT_AW+1)'(1);
            end
            if (ev_valid && (ev_entry.id == item_reg.candidate_id)) begin
                match_found_reg <= 1'b1;
            end
            if (ev_valid && better_victim) begin
                victim_found_reg <= 1'b1;
            end
            if (ev_vld_reg && !ev_valid) begin
                free_found_reg <= 1'b1;
            end

            if (cmd.hit_write) begin
                vote_index_reg <= vote_index_next;
            end
            if (cmd.insert_write) begin
                vote_index_reg             <= vote_index_next;
                slot_valid_reg[target_idx] <= 1'b1;
                if (!need_evict) begin
                    count_reg <= count_reg + CNT_SW'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
        if (cmd.scan_step) begin
            ev_idx_reg <= ptr_reg[SLOT_AW-1:0];
        end
        if (ev_valid && (ev_entry.id == item_reg.candidate_id)) begin
            match_idx_reg   <= ev_idx_reg;
            match_entry_reg <= ev_entry;
        end
        if (ev_valid && better_victim) begin
            victim_idx_reg   <= ev_idx_reg;
            victim_entry_reg <= ev_entry;
        end
        if (ev_vld_reg && !ev_valid && !free_found_reg) begin
            free_idx_reg <= ev_idx_reg;
        end
        if (cmd.list_rd) begin
            laddr_reg <= mptr_reg[MAP_AW-1:0];
        end

        if (cmd.hit_write) begin
            res_reg <= '{kind: KIND_HIT, result_id: '0, last: 1'b1};
        end else if (cmd.insert_write) begin
            if (need_evict) begin
                res_reg <= '{kind: KIND_EVICTED, result_id: victim_entry_reg.id,
                             last: 1'b1};
            end else begin
                res_reg <= '{kind: KIND_INSERTED, result_id: '0, last: 1'b1};
            end
        end else if (cmd.list_emit) begin
            res_reg <= '{kind: KIND_LISTED, result_id: ID_W'(laddr_reg),
                         last: ((CMP_W'(emitted_reg) + CMP_W'(1)) == list_total)};
        end else if (cmd.res_empty) begin
            res_reg <= '{kind: KIND_EMPTY, result_id: '0, last: 1'b1};
        end else if (cmd.res_cleared) begin
            res_reg <= '{kind: KIND_CLEARED, result_id: '0, last: 1'b1};
        end
    end

    always_comb begin
        stat.command    = item_reg.command;
        stat.id_ok      = (32'(item_reg.candidate_id) < 32'(ID_COUNT));
        stat.count_zero = (count_reg == '0);
        stat.clr_done   = (mptr_reg == (MAP_AW+1)'(ID_COUNT - 1));
        stat.scan_last  = (ptr_reg == (SLOT_AW+1)'(MAX_SLOTS - 1));
        stat.hit        = match_found_reg;
        stat.need_evict = need_evict;
        stat.map_bit    = map_rdata[0];
        stat.res_last   = res_reg.last;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- rtl/lfu_ctrl.sv -----
// sequencing state machine for vote, list and clear
`default_nettype none

module lfu_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               out_free,
    output logic                    out_load,
    input  wire lfu_pkg::lfu_stat_t stat,
    output lfu_pkg::lfu_cmd_t       cmd
);

    import lfu_pkg::*;

    typedef enum logic [10:0] {
        S_CLR      = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_DISPATCH = 11'b00000000100,
        S_SCAN     = 11'b00000001000,
        S_SCAN_END = 11'b00000010000,
        S_DECIDE   = 11'b00000100000,
        S_EVICT    = 11'b00001000000,
        S_INSERT   = 11'b00010000000,
        S_LIST_RD  = 11'b00100000000,
        S_LIST_CHK = 11'b01000000000,
        S_OUT      = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   clr_emit_reg, clr_emit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_emit_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_emit_reg <= clr_emit_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_emit_next = clr_emit_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) begin
                    clr_emit_next = 1'b0;
                    if (clr_emit_reg) begin
                        cmd.res_cleared = 1'b1;
                        state_next      = S_OUT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.command)
                    CMD_VOTE: begin
                        if (stat.id_ok) begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                    CMD_LIST: begin
                        if (stat.count_zero) begin
                            cmd.res_empty = 1'b1;
                            state_next    = S_OUT;
                        end else begin
                            cmd.list_start = 1'b1;
                            state_next     = S_LIST_RD;
                        end
                    end
                    CMD_CLEAR: begin
                        cmd.clr_start = 1'b1;
                        clr_emit_next = 1'b1;
                        state_next    = S_CLR;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (stat.hit) begin
                    cmd.hit_write = 1'b1;
                    state_next    = S_OUT;
                end else if (stat.need_evict) begin
                    state_next = S_EVICT;
                end else begin
                    state_next = S_INSERT;
                end
            end
            S_EVICT: begin
                cmd.evict_map = 1'b1;
                state_next    = S_INSERT;
            end
            S_INSERT: begin
                cmd.insert_write = 1'b1;
                state_next       = S_OUT;
            end
            S_LIST_RD: begin
                cmd.list_rd = 1'b1;
                state_next  = S_LIST_CHK;
            end
            S_LIST_CHK: begin
                if (stat.map_bit) begin
                    cmd.list_emit = 1'b1;
                    state_next    = S_OUT;
                end else begin
                    state_next = S_LIST_RD;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = stat.res_last ? S_IDLE : S_LIST_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/lfu_slot_replacement_unit.sv -----
// top level of the lfu slot replacement block
`default_nettype none

// Table of up to MAX_SLOTS resident ids with least-frequently-used
// replacement, ties broken by earliest insertion. One input item is worked
// on at a time; the output register lets the next item be accepted while
// a result still waits for m_ready. The slot table is a single-read-port ram
// and the victim/match search walks it one slot per cycle. A hit is then
// written from the decide state, a plain insert goes through an insert
// state, and an eviction through an evict state before the insert state;
// the next item can be accepted from the cycle in which m_valid rises.
// A list command walks the resident bitmap with a read state and a check
// state per id, plus an output state for each listed id, which also waits
// on m_ready. A clear command, and the pass after reset, sweep the bitmap
// ram one id per cycle, during which no item is accepted (configuration
// writes are still taken).

module lfu_slot_replacement_unit #(
    parameter int MAX_SLOTS = 32,
    parameter int ID_COUNT  = 128
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // input items
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire lfu_pkg::in_item_t         s_item,
    // result items
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output lfu_pkg::out_item_t             m_item,
    // slot_count register
    input  wire logic                      cfg_wr_en,
    input  wire logic [lfu_pkg::CFG_W-1:0] cfg_wr_data
);

    import lfu_pkg::*;

    lfu_cmd_t  cmd;
    lfu_stat_t stat;
    out_item_t res;
    logic      out_free, out_load;

    // output register
    logic      m_valid_reg;
    out_item_t m_item_reg;

    // register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    lfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfu_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .ID_COUNT  (ID_COUNT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_item      (s_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire
